[hdl/linear_scan_register_allocator_top_defines.svh]
// Assertion macros used by the register allocator datapath (lsra_dp).
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_TOP_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LSRA_ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("allocator assertion failed");

// Antecedent implies consequent in the next cycle.
`define LSRA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("allocator assertion failed");

`endif

[hdl/lsra_pkg.sv]
// Types and constants of the linear scan register allocator.
// No dependencies.
package lsra_pkg;
    localparam int MAX_REGS = 32;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int POS_W    = 16;
    localparam int VAR_W    = 10;
    localparam int REG_W    = 5;

    typedef struct packed {
        logic [VAR_W-1:0] var_num;
        logic [POS_W-1:0] end_pos;
        logic [REG_W-1:0] reg_num;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;
endpackage

[hdl/lsra_ctrl.sv]
// Controller of the register allocator: sequences load, scan and decision.
// Depends on lsra_pkg.
module lsra_ctrl
    import lsra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_DECIDE;
                else                    o_cmd.step = 1'b1;
            end
            ST_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[hdl/lsra_dp.sv]
// Datapath of the register allocator: active list, scan, decision, output register.
// Depends on lsra_pkg and the assertion macro header.
`include "linear_scan_register_allocator_top_defines.svh"
module lsra_dp
    import lsra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_register_count,
    input  logic [POS_W-1:0] i_interval_start,
    input  logic [POS_W-1:0] i_interval_end,
    input  logic [VAR_W-1:0] i_variable_number,
    input  logic             i_last_interval,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [REG_W-1:0] o_assigned_register,
    output logic             o_interval_spilled,
    output logic             o_eviction_valid,
    output logic [VAR_W-1:0] o_evicted_variable
);
    t_entry r_list [MAX_REGS];

    logic [CNT_W-1:0]    r_reg_count;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_kept;
    logic [MAX_REGS-1:0] r_used;
    logic                r_have_best;
    logic [IDX_W-1:0]    r_best_pos;
    t_entry              r_best;
    logic [POS_W-1:0]    r_start, r_end;
    logic [VAR_W-1:0]    r_var;
    logic                r_last;
    logic                r_ovalid;
    logic [REG_W-1:0]    r_oreg;
    logic                r_ospill, r_oevict;
    logic [VAR_W-1:0]    r_oevar;

    t_entry              cur;
    logic                keep;
    logic [CNT_W-1:0]    lim;
    logic [MAX_REGS-1:0] avail;
    logic [REG_W-1:0]    pick;
    logic                found;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    logic [REG_W-1:0]    d_reg;
    logic                d_spill, d_evict;
    logic [VAR_W-1:0]    d_evar;

    assign cur  = r_list[r_idx[IDX_W-1:0]];
    assign keep = (cur.end_pos >= r_start);

    assign o_status.scan_done = (r_idx == r_count);
    assign o_status.out_free  = !r_ovalid || i_ready;

    // clamp register count to 1..MAX_REGS
    always_comb begin
        if (r_reg_count == '0)                   lim = CNT_W'(1);
        else if (r_reg_count > CNT_W'(MAX_REGS)) lim = CNT_W'(MAX_REGS);
        else                                     lim = r_reg_count;
    end

    // lowest free register below the limit
    always_comb begin
        pick  = '0;
        found = 1'b0;
        for (int r = MAX_REGS - 1; r >= 0; r--) begin
            avail[r] = !r_used[r] && (CNT_W'(r) < lim);
            if (avail[r]) begin
                pick  = REG_W'(r);
                found = 1'b1;
            end
        end
    end

    // list write port and decision
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_kept[IDX_W-1:0];
        wr_data = cur;
        d_reg   = '0;
        d_spill = 1'b0;
        d_evict = 1'b0;
        d_evar  = '0;
        n_count = r_kept;
        if (i_cmd.step) begin
            wr_en = keep;
        end else if (i_cmd.decide) begin
            if (r_kept < lim) begin
                if (found) begin
                    wr_en   = 1'b1;
                    wr_data = '{var_num: r_var, end_pos: r_end, reg_num: pick};
                    d_reg   = pick;
                    n_count = r_kept + CNT_W'(1);
                end else begin
                    d_spill = 1'b1;
                end
            end else if (r_best.end_pos > r_end) begin
                wr_en   = 1'b1;
                wr_addr = r_best_pos;
                wr_data = '{var_num: r_var, end_pos: r_end, reg_num: r_best.reg_num};
                d_reg   = r_best.reg_num;
                d_evict = 1'b1;
                d_evar  = r_best.var_num;
            end else begin
                d_spill = 1'b1;
            end
            if (r_last) n_count = '0;
        end
    end

    // active list storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_list[wr_addr] <= wr_data;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= CNT_W'(MAX_REGS);
            r_count     <= '0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_have_best <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_reg_count <= i_cfg_register_count;
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_kept      <= '0;
                r_have_best <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + CNT_W'(1);
                if (keep) begin
                    r_kept <= r_kept + CNT_W'(1);
                    if (!r_have_best || cur.end_pos > r_best.end_pos) r_have_best <= 1'b1;
                end
            end
            if (i_cmd.decide) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_interval_start;
            r_end   <= i_interval_end;
            r_var   <= i_variable_number;
            r_last  <= i_last_interval;
            r_used  <= '0;
        end else if (i_cmd.step && keep) begin
            r_used[cur.reg_num] <= 1'b1;
            if (!r_have_best || cur.end_pos > r_best.end_pos) begin
                r_best     <= cur;
                r_best_pos <= r_kept[IDX_W-1:0];
            end
        end
        if (i_cmd.decide) begin
            r_oreg   <= d_reg;
            r_ospill <= d_spill;
            r_oevict <= d_evict;
            r_oevar  <= d_evar;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_assigned_register = r_oreg;
    assign o_interval_spilled  = r_ospill;
    assign o_eviction_valid    = r_oevict;
    assign o_evicted_variable  = r_oevar;

    // checks
    `LSRA_ASSERT_IMPLIES(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_REGS))
    `LSRA_ASSERT_IMPLIES(a_kept_le_idx, 1'b1, r_kept <= r_idx)
    `LSRA_ASSERT_IMPLIES(a_evict_excl, r_ovalid, !(r_oevict && r_ospill))
    `LSRA_ASSERT_NEXT(a_last_clears, i_cmd.decide && r_last, r_count == '0)
endmodule

[hdl/linear_scan_register_allocator_top.sv]
// Top level of the linear scan register allocator.
// Depends on lsra_pkg, lsra_ctrl and lsra_dp.
//
// Usage:
//  - Input channel (i_valid/o_ready) carries one live interval per transaction,
//    in nondecreasing start order; i_last_interval ends a run and empties the list.
//  - Output channel (o_valid/i_ready) returns one result per interval: assigned
//    register, spilled flag, and the evicted variable when one lost its register.
//  - Config channel (i_cfg_valid/o_cfg_ready) writes the register count; it is
//    always ready; the user must write it only while the block is idle, which the block does not enforce.
//  - After acceptance the scan walks the active list one entry per cycle, compacting it,
//    collecting used registers and the entry with the latest end; then the decision
//    step sets o_valid. o_ready is high only when idle, so a new interval is taken
//    only after the decision step of the previous one.
//  - A result waits in the output register while the next interval scans; if the
//    receiver stalls, the decision step waits until the register frees.
//  - Reset: active list empty, register count 32, no result pending.
module linear_scan_register_allocator_top
    import lsra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [POS_W-1:0] i_interval_start,
    input  logic [POS_W-1:0] i_interval_end,
    input  logic [VAR_W-1:0] i_variable_number,
    input  logic             i_last_interval,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [REG_W-1:0] o_assigned_register,
    output logic             o_interval_spilled,
    output logic             o_eviction_valid,
    output logic [VAR_W-1:0] o_evicted_variable,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_register_count
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lsra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lsra_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_register_count (i_cfg_register_count),
        .i_interval_start     (i_interval_start),
        .i_interval_end       (i_interval_end),
        .i_variable_number    (i_variable_number),
        .i_last_interval      (i_last_interval),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_assigned_register  (o_assigned_register),
        .o_interval_spilled   (o_interval_spilled),
        .o_eviction_valid     (o_eviction_valid),
        .o_evicted_variable   (o_evicted_variable)
    );
endmodule

[tb/tb_top.sv]
// Self-checking bench for linear_scan_register_allocator_top.
// Depends on lsra_pkg and the allocator RTL; a small scoreboard class predicts results.

// Scoreboard: keeps its own copy of the active list and checks each result.
class alloc_scoreboard;
    typedef struct packed {
        logic [4:0] reg_num;
        logic       spilled;
        logic       evict;
        logic [9:0] evicted;
    } t_alloc_result;

    logic [9:0]      live_var[32];
    logic [15:0]     live_end[32];
    logic [4:0]      live_reg[32];
    int              live_count;
    logic [5:0]      reg_count;
    t_alloc_result   pending[$];
    int              errors;

    function new();
        live_count = 0;
        reg_count  = 6'd32;
        errors     = 0;
    endfunction

    // Predict one allocation and queue the expected result.
    function void note_interval(logic [15:0] s, logic [15:0] e, logic [9:0] v, logic last);
        int kept;
        int lim;
        int best;
        bit found;
        bit used;
        t_alloc_result r;
        r = '0;
        kept = 0;
        lim = (reg_count < 1) ? 1 : ((reg_count > 32) ? 32 : int'(reg_count));
        // expire entries ending before the new start
        for (int i = 0; i < live_count; i++) begin
            if (live_end[i] >= s) begin
                live_var[kept] = live_var[i];
                live_end[kept] = live_end[i];
                live_reg[kept] = live_reg[i];
                kept++;
            end
        end
        live_count = kept;
        if (live_count < lim) begin
            found = 1'b0;
            for (int g = 0; g < lim && !found; g++) begin
                used = 1'b0;
                for (int i = 0; i < live_count; i++)
                    if (live_reg[i] == g) used = 1'b1;
                if (!used) begin
                    found = 1'b1;
                    r.reg_num = g[4:0];
                end
            end
            if (found) begin
                live_var[live_count] = v;
                live_end[live_count] = e;
                live_reg[live_count] = r.reg_num;
                live_count++;
            end else begin
                r.spilled = 1'b1;
                r.reg_num = '0;
            end
        end else begin
            best = 0;
            for (int i = 1; i < live_count; i++)
                if (live_end[i] > live_end[best]) best = i;
            if (live_end[best] > e) begin
                r.reg_num = live_reg[best];
                r.evict = 1'b1;
                r.evicted = live_var[best];
                live_var[best] = v;
                live_end[best] = e;
            end else begin
                r.spilled = 1'b1;
            end
        end
        if (last) live_count = 0;
        pending.push_back(r);
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(logic [4:0] rg, logic sp, logic ev, logic [9:0] evv);
        t_alloc_result x;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        x = pending.pop_front();
        if (rg !== x.reg_num) begin
            $error("assigned_register exp %0d got %0d", x.reg_num, rg); errors++;
        end
        if (sp !== x.spilled) begin
            $error("interval_spilled exp %0d got %0d", x.spilled, sp); errors++;
        end
        if (ev !== x.evict) begin
            $error("eviction_valid exp %0d got %0d", x.evict, ev); errors++;
        end
        if (evv !== x.evicted) begin
            $error("evicted_variable exp %0d got %0d", x.evicted, evv); errors++;
        end
    endfunction
endclass

module tb_top;
    import lsra_pkg::*;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_valid = 0;
    logic             o_ready;
    logic [POS_W-1:0] i_interval_start = '0;
    logic [POS_W-1:0] i_interval_end = '0;
    logic [VAR_W-1:0] i_variable_number = '0;
    logic             i_last_interval = 0;
    logic             o_valid;
    logic             i_ready = 0;
    logic [REG_W-1:0] o_assigned_register;
    logic             o_interval_spilled;
    logic             o_eviction_valid;
    logic [VAR_W-1:0] o_evicted_variable;
    logic             i_cfg_valid = 0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_register_count = '0;

    alloc_scoreboard sb;
    logic [15:0]     cur_pos;
    int              cycles = 0;
    localparam int   CYCLE_LIMIT = 400000;

    linear_scan_register_allocator_top u_top (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random stall per result, check on acceptance.
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 5) == 0) w = 0;
            if (w > 0) begin
                i_ready <= 0;
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_assigned_register, o_interval_spilled,
                            o_eviction_valid, o_evicted_variable);
        end
    end

    // Drop valid and let one falling edge pass.
    task automatic hold_input();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one interval, after a random gap when gaps is set; valid stays up until the next call.
    task automatic send_interval(logic [15:0] s, logic [15:0] e, logic [9:0] v, logic l,
                                 bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 15) : 0;
        if (gaps && $urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_valid <= 1;
        i_interval_start <= s;
        i_interval_end <= e;
        i_variable_number <= v;
        i_last_interval <= l;
        do @(posedge i_clk); while (!o_ready);
        sb.note_interval(s, e, v, l);
        @(negedge i_clk);
    endtask

    // Drain, then write the register count while idle.
    task automatic write_reg_count(logic [5:0] n);
        hold_input();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_register_count <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.reg_count = n;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Random run of mostly well-formed intervals, with a few out-of-order ones and some that end before they start.
    task automatic random_run(int n);
        logic [15:0] s;
        logic [15:0] e;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                s = 16'($urandom);
                e = 16'($urandom);
            end else begin
                cur_pos = cur_pos + 16'($urandom_range(0, 6));
                s = cur_pos;
                e = (cur_pos > 16'hFFC0) ? 16'hFFFF : cur_pos + 16'($urandom_range(0, 60));
                if ($urandom_range(0, 30) == 0) e = 16'hFFFF;
                if ($urandom_range(0, 30) == 0) e = s - 16'($urandom_range(0, 3));
            end
            send_interval(s, e, 10'($urandom), (i == n - 1) || ($urandom_range(0, 99) == 0),
                          1'b1);
            if (s > 16'hF000) cur_pos = 16'($urandom_range(0, 200));
        end
    endtask

    initial begin
        logic [5:0] counts[6] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd4, 6'd33};
        sb = new();
        cur_pos = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, eviction, self-spill, end before start, out of order.
        write_reg_count(6'd2);
        send_interval(16'd0, 16'd100, 10'd1, 1'b0, 1'b0);
        send_interval(16'd0, 16'd50, 10'd2, 1'b0, 1'b0);
        send_interval(16'd1, 16'd10, 10'd3, 1'b0, 1'b0);        // evicts the longer one
        send_interval(16'd2, 16'hFFFF, 10'h3FF, 1'b0, 1'b0);    // spilled itself
        send_interval(16'd60, 16'd40, 10'd0, 1'b0, 1'b0);       // end before start
        send_interval(16'd5, 16'd5, 10'd5, 1'b0, 1'b0);         // start order broken
        send_interval(16'hFFFF, 16'hFFFF, 10'h2AA, 1'b0, 1'b0);
        send_interval(16'hFFFF, 16'h0000, 10'h155, 1'b1, 1'b0);
        write_reg_count(6'd32);
        for (int i = 0; i < 34; i++)
            send_interval(16'd0, 16'(1000 - i), 10'(i), i == 33, 1'b0);
        write_reg_count(6'd8);
        for (int i = 0; i < 10; i++)
            send_interval(16'd0, 16'hFFFF, 10'(i), 1'b0, 1'b0);
        write_reg_count(6'd3);                                  // lowered mid-run
        send_interval(16'd1, 16'd2, 10'd77, 1'b1, 1'b0);

        // Random phases across register counts.
        foreach (counts[c]) begin
            write_reg_count(counts[c]);
            random_run(250);
        end
        for (int c = 0; c < 3; c++) begin
            write_reg_count(6'($urandom_range(1, 12)));
            random_run(120);
            hold_input();
            while (sb.pending.size() != 0) @(negedge i_clk);  // sender holds off
            random_run(50);
        end
        write_reg_count(6'($urandom));
        random_run(100);

        hold_input();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/lsra_pkg.sv
hdl/lsra_ctrl.sv
hdl/lsra_dp.sv
hdl/linear_scan_register_allocator_top.sv
tb/tb_top.sv
